@@ design/obd_rfp_pkg.sv @@
package obd_rfp_pkg;

	localparam logic [7:0] MaxLength      = 8'h07;
	localparam logic [7:0] ServiceReset   = 8'h41;
	localparam int         FrameBytes     = 8;
	localparam int         SInDataW       = 96;
	localparam int         MOutDataW      = 64;
	localparam logic [2:0] RegRespService = 3'd0;

	localparam logic [7:0] PidRpm      = 8'h0C;
	localparam logic [7:0] PidVolt     = 8'h42;
	localparam logic [7:0] PidRailPres = 8'h23;
	localparam logic [7:0] PidMaf      = 8'h10;
	localparam logic [7:0] PidRunTime  = 8'h1F;
	localparam logic [7:0] PidSpeed    = 8'h0D;
	localparam logic [7:0] PidThrottle = 8'h11;
	localparam logic [7:0] PidIntake   = 8'h0F;
	localparam logic [7:0] PidCoolant  = 8'h05;
	localparam logic [7:0] PidLoad     = 8'h04;

	typedef struct packed {
		logic load_frame;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_ok;
		logic entry_last;
		logic out_free;
	} dp_status_t;

	// Number of data bytes a known PID carries, zero when the PID is unknown.
	function automatic logic [1:0] pid_width(input logic [7:0] pid);
		logic [1:0] w;
		unique case (pid)
			PidRpm, PidVolt, PidRailPres, PidMaf, PidRunTime: w = 2'd2;
			PidSpeed, PidThrottle, PidIntake, PidCoolant, PidLoad: w = 2'd1;
			default: w = 2'd0;
		endcase
		return w;
	endfunction

endpackage

@@ design/obd_response_frame_parser_top.sv @@
// Channel   Direction  Handshake                Content
// s_axis    in         s_tvalid / s_tready      one reply frame and its sequence number
// m_axis    out        m_tvalid / m_tready      one PID entry per request
// apb       in         psel / penable / pready  response_service register at address 0
//
// A frame is taken only while the parser is idle. It is captured, then goes through the
// length and service check, then through its PID entries one at a time, up to three
// per frame; the single output register sets the pace when the sink stalls.
// Reset clears the controller and the output valid and sets response_service to 0x41.
module obd_response_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: frame_byte_0 [7:0] .. frame_byte_7 [63:56], sequence_in [95:64]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	// m_tdata: pid_code [7:0], first_data [15:8], second_data [23:16],
	// data_count [25:24], sequence_out [57:26], zero [63:58]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tlast,
	// m_tuser: unknown_pid [0]
	output logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import obd_rfp_pkg::*;

	logic [7:0] resp_service_q;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr == RegRespService);
	assign prdata  = reg_hit ? {24'd0, resp_service_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_service_q <= ServiceReset;
		end else if (psel && penable && pwrite && reg_hit) begin
			resp_service_q <= pwdata[7:0];
		end
	end

	obd_rfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	obd_rfp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tdata          (s_tdata),
		.response_service (resp_service_q),
		.cmd              (cmd),
		.status           (status),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.m_tuser          (m_tuser)
	);

endmodule

@@ design/obd_rfp_ctrl.sv @@
module obd_rfp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output obd_rfp_pkg::dp_cmd_t    cmd,
	input  obd_rfp_pkg::dp_status_t status
);
	import obd_rfp_pkg::*;

	localparam logic [1:0] StIdle  = 2'd0;
	localparam logic [1:0] StCheck = 2'd1;
	localparam logic [1:0] StWalk  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == StIdle);

	always_comb begin
		state_d        = state_q;
		cmd.load_frame = 1'b0;
		cmd.emit       = 1'b0;
		unique case (state_q)
			StIdle: begin
				if (s_tvalid) begin
					cmd.load_frame = 1'b1;
					state_d        = StCheck;
				end
			end
			StCheck: begin
				state_d = status.frame_ok ? StWalk : StIdle;
			end
			StWalk: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.entry_last) begin
						state_d = StIdle;
					end
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/obd_rfp_dp.sv @@
module obd_rfp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [obd_rfp_pkg::SInDataW-1:0]  s_tdata,
	input  logic [7:0]                        response_service,
	input  obd_rfp_pkg::dp_cmd_t               cmd,
	output obd_rfp_pkg::dp_status_t            status,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [obd_rfp_pkg::MOutDataW-1:0] m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);
	import obd_rfp_pkg::*;

	logic [FrameBytes-1:0][7:0] frame_q;
	logic [31:0] seq_q;
	logic [3:0]  pos_q;
	logic [1:0]  cnt_q;

	logic        out_valid_q;
	logic [7:0]  pid_out_q;
	logic [7:0]  d0_out_q;
	logic [7:0]  d1_out_q;
	logic [1:0]  dcnt_out_q;
	logic [31:0] seq_out_q;
	logic        unk_out_q;
	logic        last_out_q;

	logic [7:0] len;
	logic [3:0] lim;
	logic [7:0] pid;
	logic [7:0] d0;
	logic [7:0] d1;
	logic [1:0] w;
	logic       unknown;
	logic [1:0] dcnt;
	logic [3:0] pos_nx;
	logic       last;

	// Bytes beyond the end of the frame read as zero.
	function automatic logic [7:0] byte_at(input logic [FrameBytes-1:0][7:0] fr,
			input logic [3:0] idx);
		logic [7:0] b;
		b = idx[3] ? 8'h00 : fr[idx[2:0]];
		return b;
	endfunction

	assign len     = frame_q[0];
	assign lim     = len[3:0] - 4'd1;
	assign pid     = byte_at(frame_q, pos_q + 4'd2);
	assign w       = pid_width(pid);
	assign unknown = (w == 2'd0);
	assign dcnt    = unknown ? 2'd1 : w;
	assign d0      = byte_at(frame_q, pos_q + 4'd3);
	assign d1      = (w == 2'd2) ? byte_at(frame_q, pos_q + 4'd4) : 8'h00;
	assign pos_nx  = pos_q + {2'b00, dcnt} + 4'd1;
	assign last    = unknown || !(pos_nx < lim) || (cnt_q == 2'd2);

	// A length of one fails the frame checks and so yields no entries.
	assign status.frame_ok   = (len >= 8'd2) && (len <= MaxLength)
		&& (frame_q[1] == response_service);
	assign status.entry_last = last;
	assign status.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load_frame) begin
			frame_q <= s_tdata[63:0];
			seq_q   <= s_tdata[64 +: 32];
			pos_q   <= 4'd0;
			cnt_q   <= 2'd0;
		end else if (cmd.emit) begin
			pos_q <= pos_nx;
			cnt_q <= cnt_q + 2'd1;
		end
		if (cmd.emit) begin
			pid_out_q  <= pid;
			d0_out_q   <= d0;
			d1_out_q   <= d1;
			dcnt_out_q <= dcnt;
			seq_out_q  <= seq_q;
			unk_out_q  <= unknown;
			last_out_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, seq_out_q, dcnt_out_q, d1_out_q, d0_out_q, pid_out_q};
	assign m_tlast  = last_out_q;
	assign m_tuser  = unk_out_q;

endmodule

@@ bench/obd_response_frame_parser_top_tb.sv @@
module obd_response_frame_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obd_rfp_pkg::*;

	typedef logic [7:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0]  pid;
		logic [7:0]  d0;
		logic [7:0]  d1;
		logic [1:0]  cnt;
		logic [31:0] seq;
		logic        unk;
		logic        last;
	} pid_entry_t;

	typedef struct {
		frame_t     fr;
		logic [31:0] seq;
		int         n;
		pid_entry_t ent;
	} frame_row_t;

	typedef enum {RxAlways, RxCoin, RxSparse, RxPeriodic} rx_mode_t;

	localparam logic [2:0] ServiceAddr = 3'(4 * RegRespService);
	localparam logic [2:0] UnusedAddr  = 3'd4;
	localparam int         SettleCycles = 12;
	localparam logic [7:0] KnownPids [10] = '{PidRpm, PidVolt, PidRailPres, PidMaf, PidRunTime,
		PidSpeed, PidThrottle, PidIntake, PidCoolant, PidLoad};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pid_entry_t  pending_pid_entries [$];
	frame_row_t  frame_rows [$];
	logic [7:0]  resp_service = ServiceReset;
	int          fail_count = 0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RxAlways;
	int          rx_mode_cycles = 0;

	obd_response_frame_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int data_bytes(input logic [7:0] pid);
		case (pid)
			PidRpm, PidVolt, PidRailPres, PidMaf, PidRunTime: return 2;
			PidSpeed, PidThrottle, PidIntake, PidCoolant, PidLoad: return 1;
			default: return 0;
		endcase
	endfunction

	// Bytes beyond the eight-byte frame read as zero.
	function automatic logic [7:0] byte_at(input frame_t fr, input int idx);
		if (idx > 7) begin
			return 8'h00;
		end
		return fr[idx];
	endfunction

	function automatic void walk_frame(input frame_t fr, input logic [31:0] seq);
		int         len;
		int         pos;
		int         cnt;
		int         w;
		pid_entry_t e;
		len = fr[0];
		pos = 0;
		cnt = 0;
		if (len == 0 || len > MaxLength || fr[1] != resp_service) begin
			return;
		end
		while (pos < len - 1 && cnt < 3) begin
			e.pid = byte_at(fr, 2 + pos);
			w = data_bytes(e.pid);
			e.unk = (w == 0);
			e.d0 = byte_at(fr, 3 + pos);
			e.d1 = (w == 2) ? byte_at(fr, 4 + pos) : 8'h00;
			e.cnt = e.unk ? 2'd1 : 2'(w);
			e.seq = seq;
			pos += (e.unk ? 1 : w) + 1;
			e.last = e.unk || !(pos < len - 1) || cnt == 2;
			pending_pid_entries.push_back(e);
			cnt++;
			if (e.unk) begin
				break;
			end
		end
	endfunction

	// Mostly well-formed replies whose PIDs follow the walk, with some noise mixed in.
	function automatic frame_t make_random_frame();
		frame_t fr;
		int     r;
		int     pos;
		int     w;
		for (int k = 0; k < FrameBytes; k++) begin
			fr[k] = 8'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			fr[0] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(8, 255));
		end else if (r < 12) begin
			fr[0] = 8'($urandom_range(1, 7));
			fr[1] = resp_service ^ 8'($urandom_range(1, 255));
		end else begin
			fr[0] = 8'($urandom_range(1, 7));
			fr[1] = resp_service;
			pos = 0;
			while (pos < fr[0] - 1) begin
				if ($urandom_range(0, 9) < 8) begin
					fr[2 + pos] = KnownPids[$urandom_range(0, 9)];
				end
				w = data_bytes(fr[2 + pos]);
				if (w == 0) begin
					break;
				end
				pos += w + 1;
			end
		end
		return fr;
	endfunction

	function automatic frame_t make_frame(input logic [7:0] len, svc, input logic [47:0] pl);
		frame_t fr;
		fr[0] = len;
		fr[1] = svc;
		for (int k = 2; k < FrameBytes; k++) begin
			fr[k] = pl[47 - 8 * (k - 2) -: 8];
		end
		return fr;
	endfunction

	// A negative count leaves the expectation to the predictor.
	task automatic add_row(input logic [7:0] len, svc, input logic [47:0] pl,
			input logic [31:0] seq, input int n, input logic [7:0] pid, d0, d1,
			input logic [1:0] cnt, input logic unk);
		frame_row_t row;
		row.fr = make_frame(len, svc, pl);
		row.seq = seq;
		row.n = n;
		row.ent = '{pid: pid, d0: d0, d1: d1, cnt: cnt, seq: seq, unk: unk, last: 1'b1};
		frame_rows.push_back(row);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
		logic [31:0] rd;
		apb_access(1'b1, addr, {24'h0, val}, rd);
		if (addr == ServiceAddr) begin
			resp_service = val;
		end
		apb_access(1'b0, ServiceAddr, 32'h0, rd);
		check_field("response_service readback", {24'h0, resp_service}, rd);
	endtask

	// Sender in bursts: a gap of idle cycles comes before each new burst.
	task automatic drive_frame(input frame_t fr, input logic [31:0] seq);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 10);
		end
		s_tdata <= {seq, fr};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_pid_entries.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (rx_mode_cycles == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_cycles = $urandom_range(20, 120);
		end
		rx_mode_cycles--;
		case (rx_mode)
			RxAlways: m_tready <= 1'b1;
			RxCoin: m_tready <= 1'($urandom_range(0, 1));
			RxSparse: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= rx_mode_cycles[2];
		endcase
	end

	always @(posedge clk) begin
		pid_entry_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pid_entries.size() == 0) begin
				$display("%0t: unexpected entry, expected none, got %0h", $time, m_tdata);
				fail_count++;
			end else begin
				e = pending_pid_entries.pop_front();
				check_field("pid_code", e.pid, m_tdata[7:0]);
				check_field("first_data", e.d0, m_tdata[15:8]);
				check_field("second_data", e.d1, m_tdata[23:16]);
				check_field("data_count", e.cnt, m_tdata[25:24]);
				check_field("sequence_out", e.seq, m_tdata[57:26]);
				check_field("tdata padding", 0, m_tdata[63:58]);
				check_field("unknown_pid", e.unk, m_tuser);
				check_field("last_entry", e.last, m_tlast);
			end
		end
	end

	initial begin
		logic [7:0]  phase_service [6];
		frame_t      fr;
		logic [31:0] seq;
		int          guard;

		// Dropped frames: bad length and wrong service byte.
		add_row(8'h00, 8'h41, 48'h0C1122334455, 32'h0000_0000, 0, 0, 0, 0, 0, 0);
		add_row(8'h08, 8'h41, 48'h0C1122334455, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
		add_row(8'hFF, 8'h41, 48'h0D1122334455, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h40, 48'h0D5500000000, 32'h0000_0002, 0, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'hFF, 48'h0D5500000000, 32'h0000_0003, 0, 0, 0, 0, 0, 0);
		// A length of one yields no PID entry.
		add_row(8'h01, 8'h41, 48'h0C1122334455, 32'h0000_0004, 0, 0, 0, 0, 0, 0);
		add_row(8'h03, 8'h41, 48'h0C1AF8000000, 32'hFFFF_FFFF, 1,
			8'h0C, 8'h1A, 8'hF8, 2'd2, 1'b0);
		add_row(8'h02, 8'h41, 48'h0DFF00000000, 32'h0000_0000, 1,
			8'h0D, 8'hFF, 8'h00, 2'd1, 1'b0);
		add_row(8'h07, 8'h41, 48'hFFAA00000000, 32'h8000_0000, 1,
			8'hFF, 8'hAA, 8'h00, 2'd1, 1'b1);
		add_row(8'h07, 8'h41, 48'h000000000000, 32'h0000_0000, 1,
			8'h00, 8'h00, 8'h00, 2'd1, 1'b1);
		add_row(8'h07, 8'h41, 48'hFFFFFFFFFFFF, 32'hFFFF_FFFF, 1,
			8'hFF, 8'hFF, 8'h00, 2'd1, 1'b1);
		// The PID entries run up to or past the end of the frame.
		add_row(8'h07, 8'h41, 48'h0C01020D0305, 32'h1234_5678, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h04A011B10FC0, 32'hA5A5_A5A5, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h42A1B223C3D3, 32'h5A5A_5A5A, -1, 0, 0, 0, 0, 0);
		// Data bytes beyond the length count are still taken.
		add_row(8'h06, 8'h41, 48'h10A1B21FC3D3, 32'h0F0F_0F0F, -1, 0, 0, 0, 0, 0);
		add_row(8'h04, 8'h41, 48'h0C11220D3300, 32'hF0F0_F0F0, -1, 0, 0, 0, 0, 0);
		add_row(8'h05, 8'h41, 48'h0CAABB0DCC00, 32'h0000_FFFF, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h0CAABB77CC00, 32'hFFFF_0000, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h0D110DFE0DEE, 32'h0000_0010, -1, 0, 0, 0, 0, 0);
		add_row(8'h02, 8'h41, 48'h0C1234000000, 32'h0000_0020, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h1F0102420304, 32'h0000_0040, -1, 0, 0, 0, 0, 0);
		add_row(8'h03, 8'h41, 48'h23FFFF000000, 32'h7FFF_FFFF, -1, 0, 0, 0, 0, 0);
		add_row(8'h07, 8'h41, 48'h05800F7F1101, 32'hDEAD_BEEF, -1, 0, 0, 0, 0, 0);

		phase_service[0] = 8'h00;
		phase_service[1] = 8'hFF;
		phase_service[2] = ServiceReset;
		phase_service[3] = 8'($urandom_range(0, 255));
		phase_service[4] = 8'($urandom_range(0, 255));
		phase_service[5] = ServiceReset;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// A write outside the register map must leave the service code alone.
		write_reg(UnusedAddr, 8'h00);

		foreach (frame_rows[i]) begin
			drive_frame(frame_rows[i].fr, frame_rows[i].seq);
			if (frame_rows[i].n < 0) begin
				walk_frame(frame_rows[i].fr, frame_rows[i].seq);
			end else if (frame_rows[i].n > 0) begin
				pending_pid_entries.push_back(frame_rows[i].ent);
			end
		end

		foreach (phase_service[p]) begin
			wait_idle();
			write_reg(ServiceAddr, phase_service[p]);
			for (int i = 0; i < 65; i++) begin
				fr = make_random_frame();
				seq = $urandom;
				drive_frame(fr, seq);
				walk_frame(fr, seq);
				if ($urandom_range(0, 39) == 0) begin
					wait_idle();
				end
			end
		end
		s_tvalid <= 1'b0;

		guard = 0;
		while (pending_pid_entries.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (pending_pid_entries.size() != 0) begin
			$display("%0t: missing entries, expected 0 left, got %0d", $time,
				pending_pid_entries.size());
			fail_count++;
		end

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
